@@ design/ocg_pkg.sv @@
// Shared constants, types and helpers for the OSD character generator.
// Depends on nothing; imported by ocg_glyph_ram, osd_character_generator_unit and the testbench.
`default_nettype none

package ocg_pkg;

  localparam int MAX_FONT_WIDTH  = 32;
  localparam int MAX_FONT_HEIGHT = 32;
  localparam int GLYPH_COUNT     = 256;

  localparam int ROW_BYTES    = (MAX_FONT_WIDTH + 7) / 8;
  localparam int GLYPH_BYTES  = ROW_BYTES * MAX_FONT_HEIGHT;
  localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_BYTES;
  localparam int CODE_W       = $clog2(GLYPH_COUNT);
  localparam int BYTE_IDX_W   = $clog2(GLYPH_BYTES);
  localparam int STORE_ADDR_W = CODE_W + BYTE_IDX_W;

  localparam int FONT_DIM_W = 6;
  localparam int STRIDE_W   = 13;
  localparam int COLOR_W    = 24;
  localparam int PIX_IDX_W  = 18;
  localparam int PIX_VAL_W  = 16;
  localparam int COL_W      = 5;
  localparam int BPR_W      = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_WIDTH  = 3'd0,
    CFG_FONT_HEIGHT = 3'd1,
    CFG_LINE_STRIDE = 3'd2,
    CFG_TEXT_COLOR  = 3'd3,
    CFG_BG_COLOR    = 3'd4,
    CFG_BG_MODE     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [7:0]              data;
  } glyph_wr_t;

  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
  } glyph_rd_t;

  // Keep the top five bits of each channel, set alpha.
  function automatic logic [PIX_VAL_W-1:0] to_1555(input logic [COLOR_W-1:0] rgb);
    return {1'b1, rgb[23:19], rgb[15:11], rgb[7:3]};
  endfunction

endpackage

`default_nettype wire

@@ design/ocg_glyph_ram.sv @@
// Glyph store: one write port, one registered read port, byte wide.
// Depends on ocg_pkg for depth and port structs.
`default_nettype none

module ocg_glyph_ram
  import ocg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire glyph_wr_t wr_i,
  input  wire glyph_rd_t rd_i,
  output logic [7:0]     rdata_o
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/osd_character_generator_unit.sv @@
// OSD character generator. A load transaction stores one glyph byte. A render
// transaction emits one ARGB1555 pixel per cycle while the output is not stalled,
// font-width pixels per row (8 at the default font), and the next transaction is
// taken on the cycle the last column leaves the sequencer, so rows stream back to
// back. The glyph store is one byte-wide memory read once per eight columns through
// its registered read port; a row's pixels pass the sequencer, bit-select and output
// registers in turn. Renders whose row is at or past the font height, or with width
// zero, give nothing. Depends on ocg_pkg and ocg_glyph_ram.
`default_nettype none

module osd_character_generator_unit
  import ocg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  action_i,
  input  wire logic [7:0]            char_code_i,
  input  wire logic [6:0]            char_position_i,
  input  wire logic [4:0]            glyph_row_i,
  input  wire logic [6:0]            glyph_byte_index_i,
  input  wire logic [7:0]            glyph_byte_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_IDX_W-1:0]       pixel_index_o,
  output logic [PIX_VAL_W-1:0]       pixel_value_o,
  output logic                       write_pixel_o,
  output logic                       last_pixel_o
);

  // Configuration registers
  logic [FONT_DIM_W-1:0] font_width_q, font_height_q;
  logic [STRIDE_W-1:0]   line_stride_q;
  logic [COLOR_W-1:0]    text_color_q, bg_color_q;
  logic                  bg_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_width_q  <= FONT_DIM_W'(8);
      font_height_q <= FONT_DIM_W'(16);
      line_stride_q <= STRIDE_W'(576);
      text_color_q  <= COLOR_W'(24'h00FF00);
      bg_color_q    <= '0;
      bg_mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FONT_WIDTH:  font_width_q  <= cfg_data_i[FONT_DIM_W-1:0];
        CFG_FONT_HEIGHT: font_height_q <= cfg_data_i[FONT_DIM_W-1:0];
        CFG_LINE_STRIDE: line_stride_q <= cfg_data_i[STRIDE_W-1:0];
        CFG_TEXT_COLOR:  text_color_q  <= cfg_data_i[COLOR_W-1:0];
        CFG_BG_COLOR:    bg_color_q    <= cfg_data_i[COLOR_W-1:0];
        CFG_BG_MODE:     bg_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective font geometry
  logic [FONT_DIM_W-1:0] w_eff, h_eff;
  logic [BPR_W-1:0]      bpr;

  assign w_eff = (font_width_q > FONT_DIM_W'(MAX_FONT_WIDTH)) ?
                 FONT_DIM_W'(MAX_FONT_WIDTH) : font_width_q;
  assign h_eff = (font_height_q > FONT_DIM_W'(MAX_FONT_HEIGHT)) ?
                 FONT_DIM_W'(MAX_FONT_HEIGHT) : font_height_q;
  assign bpr   = BPR_W'((FONT_DIM_W'(w_eff) + FONT_DIM_W'(7)) >> 3);

  // Pipeline enable: everything moves unless a result is held by the sink
  logic en;
  assign en = !(out_valid_o && out_stall_i);

  // Sequencer stage: walks the columns of one row
  logic                  a_valid_q;
  logic [CODE_W-1:0]     a_code_q;
  logic [COL_W-1:0]      a_col_q;
  logic [FONT_DIM_W-1:0] a_w_q;
  logic [BYTE_IDX_W-1:0] a_addr_q;
  logic [PIX_IDX_W-1:0]  a_idx_q;
  logic                  a_last;

  assign a_last = ({1'b0, a_col_q} + FONT_DIM_W'(1)) == a_w_q;

  logic take, take_load, take_render, render_ok;
  logic [PIX_IDX_W-1:0] row_off, pos_off, base;

  assign in_stall_o  = !(en && (!a_valid_q || a_last));
  assign take        = in_valid_i && !in_stall_o;
  assign render_ok   = (w_eff != '0) && ({1'b0, glyph_row_i} < h_eff);
  assign take_load   = take && !action_i;
  assign take_render = take && action_i && render_ok;

  assign row_off = PIX_IDX_W'(glyph_row_i) * PIX_IDX_W'(line_stride_q);
  assign pos_off = PIX_IDX_W'(char_position_i) * PIX_IDX_W'(w_eff);
  assign base    = row_off + pos_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      if (take_render) begin
        a_valid_q <= 1'b1;
      end else if (a_valid_q && a_last) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_render) begin
      a_code_q <= char_code_i;
      a_col_q  <= '0;
      a_w_q    <= w_eff;
      a_addr_q <= BYTE_IDX_W'(glyph_row_i) * BYTE_IDX_W'(bpr);
      a_idx_q  <= base;
    end else if (en && a_valid_q && !a_last) begin
      a_col_q <= a_col_q + COL_W'(1);
      a_idx_q <= a_idx_q + PIX_IDX_W'(1);
      if (a_col_q[2:0] == 3'd7) begin
        a_addr_q <= a_addr_q + BYTE_IDX_W'(1);
      end
    end
  end

  // Glyph store
  glyph_wr_t  ram_wr;
  glyph_rd_t  ram_rd;
  logic [7:0] ram_rdata;

  assign ram_wr.en   = take_load;
  assign ram_wr.addr = {char_code_i, glyph_byte_index_i};
  assign ram_wr.data = glyph_byte_i;
  // Fetch a new byte at the first column of every group of eight
  assign ram_rd.en   = en && a_valid_q && (a_col_q[2:0] == 3'd0);
  assign ram_rd.addr = {a_code_q, a_addr_q};

  ocg_glyph_ram u_glyph_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .rd_i    (ram_rd),
    .rdata_o (ram_rdata)
  );

  // Bit select stage
  logic                 b_valid_q;
  logic                 b_first_q;
  logic [2:0]           b_sel_q;
  logic [PIX_IDX_W-1:0] b_idx_q;
  logic                 b_last_q;
  logic [7:0]           hold_q;
  logic [7:0]           cur_byte;
  logic                 cur_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_first_q <= (a_col_q[2:0] == 3'd0);
      b_sel_q   <= a_col_q[2:0];
      b_idx_q   <= a_idx_q;
      b_last_q  <= a_last;
      if (b_valid_q) begin
        hold_q <= cur_byte;
      end
    end
  end

  assign cur_byte = b_first_q ? ram_rdata : hold_q;
  assign cur_bit  = cur_byte[3'd7 - b_sel_q];

  // Output register
  logic                 out_valid_q;
  logic [PIX_IDX_W-1:0] pixel_index_q;
  logic [PIX_VAL_W-1:0] pixel_value_q;
  logic                 write_pixel_q;
  logic                 last_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && b_valid_q) begin
      pixel_index_q <= b_idx_q;
      last_pixel_q  <= b_last_q;
      if (cur_bit) begin
        pixel_value_q <= to_1555(text_color_q);
        write_pixel_q <= 1'b1;
      end else if (bg_mode_q) begin
        pixel_value_q <= to_1555(bg_color_q);
        write_pixel_q <= 1'b1;
      end else begin
        pixel_value_q <= '0;
        write_pixel_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pixel_index_q;
  assign pixel_value_o = pixel_value_q;
  assign write_pixel_o = write_pixel_q;
  assign last_pixel_o  = last_pixel_q;

  // Assertions
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> ({1'b0, a_col_q} < a_w_q))
    else $error("sequencer column beyond row width");

  a_row_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_pixel_o) |=> out_valid_o)
    else $error("row broken before its last pixel");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_pixel_o) |-> (pixel_value_o == '0))
    else $error("skipped pixel carries a color");

endmodule

`default_nettype wire

@@ tb/osd_character_generator_unit_test.sv @@
// Self-checking testbench for osd_character_generator_unit: glyph loads and row renders,
// each pixel compared with an in-bench prediction of the glyph store and color path.
// Depends on ocg_pkg and the osd_character_generator_unit RTL.
module osd_character_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ocg_pkg::*;

  localparam logic ACT_LOAD        = 1'b0;
  localparam logic ACT_RENDER      = 1'b1;
  localparam int   PREDICT         = -1;
  localparam int   SETTLE_CYCLES   = 40;
  localparam int   WATCHDOG_LIMIT  = 2000;
  localparam int   ITEMS_PER_PHASE = 30;
  localparam int   RANDOM_PHASES   = 6;
  localparam int   MAX_ERR_LINES   = 40;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] index;
    logic [PIX_VAL_W-1:0] color;
    logic                 wr;
    logic                 last;
  } pixel_t;

  // One stimulus row: a register write or a transaction. n_exp >= 0 means the
  // pixels are typed in (uniform row of n_exp pixels starting at idx0).
  typedef struct {
    logic                  is_cfg;
    cfg_idx_e              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  act;
    logic [7:0]            code;
    logic [6:0]            pos;
    logic [4:0]            row;
    logic [6:0]            bidx;
    logic [7:0]            bits;
    int                    n_exp;
    logic [PIX_IDX_W-1:0]  idx0;
    logic [PIX_VAL_W-1:0]  color;
    logic                  wr;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_index = CFG_FONT_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  action = ACT_LOAD;
  logic [7:0]            char_code = '0;
  logic [6:0]            char_pos = '0;
  logic [4:0]            glyph_row = '0;
  logic [6:0]            byte_index = '0;
  logic [7:0]            glyph_bits = '0;
  logic                  out_stall = 1'b0;

  logic                  in_stall;
  logic                  out_valid;
  logic [PIX_IDX_W-1:0]  pixel_index;
  logic [PIX_VAL_W-1:0]  pixel_value;
  logic                  write_pixel;
  logic                  last_pixel;

  // Register shadows, reset values
  logic [FONT_DIM_W-1:0] font_w = 6'd8;
  logic [FONT_DIM_W-1:0] font_h = 6'd16;
  logic [STRIDE_W-1:0]   stride = 13'd576;
  logic [COLOR_W-1:0]    text_rgb = 24'h00FF00;
  logic [COLOR_W-1:0]    bg_rgb = 24'h000000;
  logic                  bg_on = 1'b0;

  logic [7:0] glyph_mirror [STORE_DEPTH];
  bit         glyph_written [STORE_DEPTH];
  logic [7:0] code_pool [8];
  pixel_t     pending_pixels [$];

  int err_count = 0;
  int accepted_items = 0;
  int load_count = 0;
  int render_count = 0;
  int pixels_checked = 0;
  int reg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  stim_row_t directed_rows [37] = '{
    // reset settings: 8 wide, 16 high, stride 576, green text, no background
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd0,   7'd0,   5'd0,  7'd0,   8'hFF,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd0,   7'd0,   5'd0,  7'd0,   8'h00,
      8, 18'd0, 16'h83E0, 1'b1},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd255, 7'd0,   5'd0,  7'd15,  8'h00,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd255, 7'd127, 5'd15, 7'd127, 8'hFF,
      8, 18'd9656, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd0,   7'd0,   5'd0,  7'd16,  8'h3C,
      PREDICT, 18'd0, 16'h0, 1'b0},
    // row past the font height
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd0,   7'd5,   5'd16, 7'd0,   8'h00,
      0, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd1,   7'd0,   5'd0,  7'd0,   8'hA5,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd1,   7'd3,   5'd0,  7'd0,   8'h00,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd128, 7'd127, 5'd31, 7'd127, 8'h5A,
      PREDICT, 18'd0, 16'h0, 1'b0},
    // widest, tallest font, white on black with background on
    '{1'b1, CFG_FONT_WIDTH,  24'd32,      ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_FONT_HEIGHT, 24'd32,      ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_LINE_STRIDE, 24'd4096,    ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_TEXT_COLOR,  24'hFFFFFF,  ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_BG_COLOR,    24'h000000,  ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_BG_MODE,     24'd1,       ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd124, 8'hFF,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd125, 8'h00,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd126, 8'h81,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd127, 8'h7E,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd200, 7'd127, 5'd31, 7'd0,   8'h00,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd0,   8'hFF,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd1,   8'hFF,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd2,   8'hFF,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_LOAD,   8'd200, 7'd0,   5'd0,  7'd3,   8'hFF,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd200, 7'd0,   5'd0,  7'd0,   8'h00,
      32, 18'd0, 16'hFFFF, 1'b1},
    // zero width renders nothing
    '{1'b1, CFG_FONT_WIDTH,  24'd0,       ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd200, 7'd0,   5'd0,  7'd0,   8'h00,
      0, 18'd0, 16'h0, 1'b0},
    // oversized width and height clamp, stride beyond its nominal range
    '{1'b1, CFG_FONT_WIDTH,  24'd63,      ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_FONT_HEIGHT, 24'd63,      ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_LINE_STRIDE, 24'd8191,    ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd200, 7'd127, 5'd31, 7'd0,   8'h00,
      PREDICT, 18'd0, 16'h0, 1'b0},
    // one-pixel font
    '{1'b1, CFG_FONT_WIDTH,  24'd1,       ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_FONT_HEIGHT, 24'd1,       ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_BG_MODE,     24'd0,       ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b1, CFG_TEXT_COLOR,  24'h123456,  ACT_LOAD, 8'd0, 7'd0, 5'd0, 7'd0, 8'h0,
      PREDICT, 18'd0, 16'h0, 1'b0},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd1,   7'd127, 5'd0,  7'd0,   8'h00,
      1, 18'd127, 16'h88CA, 1'b1},
    '{1'b0, CFG_FONT_WIDTH, 24'h0, ACT_RENDER, 8'd200, 7'd0,   5'd1,  7'd0,   8'h00,
      0, 18'd0, 16'h0, 1'b0}
  };

  osd_character_generator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .action_i           (action),
    .char_code_i        (char_code),
    .char_position_i    (char_pos),
    .glyph_row_i        (glyph_row),
    .glyph_byte_index_i (byte_index),
    .glyph_byte_i       (glyph_bits),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .pixel_index_o      (pixel_index),
    .pixel_value_o      (pixel_value),
    .write_pixel_o      (write_pixel),
    .last_pixel_o       (last_pixel)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= MAX_ERR_LINES) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  function automatic logic [PIX_VAL_W-1:0] rgb24_to_argb1555(logic [COLOR_W-1:0] rgb);
    int r;
    int g;
    int b;
    r = rgb[23:16] >> 3;
    g = rgb[15:8] >> 3;
    b = rgb[7:0] >> 3;
    return PIX_VAL_W'(32'h8000 | (r << 10) | (g << 5) | b);
  endfunction

  function automatic int eff_width();
    return (font_w > MAX_FONT_WIDTH) ? MAX_FONT_WIDTH : int'(font_w);
  endfunction

  function automatic int eff_height();
    return (font_h > MAX_FONT_HEIGHT) ? MAX_FONT_HEIGHT : int'(font_h);
  endfunction

  // Expected pixels of one glyph row, leftmost first
  task automatic predict_glyph_row(logic [7:0] code, logic [6:0] pos, logic [4:0] row);
    int         w;
    int         h;
    int         bpr;
    int         base;
    int         c;
    logic [7:0] bits;
    logic       set;
    pixel_t     p;
    w = eff_width();
    h = eff_height();
    if (w == 0 || row >= h) return;
    bpr = (w + 7) / 8;
    base = row * stride + pos * w;
    for (c = 0; c < w; c++) begin
      bits = glyph_mirror[code * GLYPH_BYTES + row * bpr + c / 8];
      set = bits[7 - c % 8];
      p.index = PIX_IDX_W'(base + c);
      p.wr = set | bg_on;
      if (set) p.color = rgb24_to_argb1555(text_rgb);
      else if (bg_on) p.color = rgb24_to_argb1555(bg_rgb);
      else p.color = '0;
      p.last = (c == w - 1);
      pending_pixels.push_back(p);
    end
  endtask

  task automatic commit_item(stim_row_t r);
    int     c;
    pixel_t p;
    accepted_items++;
    if (r.act == ACT_LOAD) begin
      glyph_mirror[r.code * GLYPH_BYTES + r.bidx] = r.bits;
      glyph_written[r.code * GLYPH_BYTES + r.bidx] = 1'b1;
      load_count++;
    end else begin
      render_count++;
      if (r.n_exp == PREDICT) begin
        predict_glyph_row(r.code, r.pos, r.row);
      end else begin
        for (c = 0; c < r.n_exp; c++) begin
          p.index = r.idx0 + PIX_IDX_W'(c);
          p.color = r.color;
          p.wr = r.wr;
          p.last = (c == r.n_exp - 1);
          pending_pixels.push_back(p);
        end
      end
    end
  endtask

  // Hold the transaction until accepted; valid stays high on return
  task automatic send(stim_row_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    action     <= r.act;
    char_code  <= r.code;
    char_pos   <= r.pos;
    glyph_row  <= r.row;
    byte_index <= r.bidx;
    glyph_bits <= r.bits;
    do @(posedge clk_i); while (in_stall);
    commit_item(r);
  endtask

  // Drain every outstanding pixel, then give the unit time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e sel, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk_i);
    reg_writes++;
    case (sel)
      CFG_FONT_WIDTH:  font_w = val[FONT_DIM_W-1:0];
      CFG_FONT_HEIGHT: font_h = val[FONT_DIM_W-1:0];
      CFG_LINE_STRIDE: stride = val[STRIDE_W-1:0];
      CFG_TEXT_COLOR:  text_rgb = val[COLOR_W-1:0];
      CFG_BG_COLOR:    bg_rgb = val[COLOR_W-1:0];
      CFG_BG_MODE:     bg_on = val[0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t make_item(logic act, logic [7:0] code, logic [6:0] pos,
                                          logic [4:0] row, logic [6:0] bidx,
                                          logic [7:0] bits);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_sel = CFG_FONT_WIDTH;
    r.reg_val = '0;
    r.act     = act;
    r.code    = code;
    r.pos     = pos;
    r.row     = row;
    r.bidx    = bidx;
    r.bits    = bits;
    r.n_exp   = PREDICT;
    r.idx0    = '0;
    r.color   = '0;
    r.wr      = 1'b0;
    return r;
  endfunction

  // Mostly well-formed: load the bytes a row needs, then render it.
  // The rest are stray loads and rows past the font height.
  task automatic random_step();
    logic [7:0] code;
    logic [4:0] row;
    int         w;
    int         h;
    int         bpr;
    int         k;
    int         addr;
    if ($urandom_range(99) < 12) begin
      send(make_item(ACT_LOAD, 8'($urandom_range(255)), 7'($urandom_range(127)),
                     5'($urandom_range(31)), 7'($urandom_range(127)),
                     8'($urandom_range(255))));
      return;
    end
    code = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : code_pool[$urandom_range(7)];
    h = eff_height();
    if (h == 0 || $urandom_range(9) == 0) row = 5'($urandom_range(31));
    else row = 5'($urandom_range(h - 1));
    w = eff_width();
    if (w > 0) begin
      bpr = (w + 7) / 8;
      for (k = 0; k < bpr; k++) begin
        addr = row * bpr + k;
        if (!glyph_written[code * GLYPH_BYTES + addr] || $urandom_range(9) == 0)
          send(make_item(ACT_LOAD, code, 7'($urandom_range(127)), 5'($urandom_range(31)),
                         7'(addr), 8'($urandom_range(255))));
      end
    end
    send(make_item(ACT_RENDER, code, 7'($urandom_range(127)), row,
                   7'($urandom_range(127)), 8'($urandom_range(255))));
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      flag_error($sformatf("unexpected pixel: index %0d value %h", pixel_index, pixel_value));
      return;
    end
    want = pending_pixels.pop_front();
    pixels_checked++;
    if (pixel_index !== want.index)
      flag_error($sformatf("pixel_index %0d, expected %0d", pixel_index, want.index));
    if (pixel_value !== want.color)
      flag_error($sformatf("pixel_value %h at index %0d, expected %h",
                           pixel_value, want.index, want.color));
    if (write_pixel !== want.wr)
      flag_error($sformatf("write_pixel %b at index %0d, expected %b",
                           write_pixel, want.index, want.wr));
    if (last_pixel !== want.last)
      flag_error($sformatf("last_pixel %b at index %0d, expected %b",
                           last_pixel, want.index, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_pixel();
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Stop on a long stretch with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] ERROR: timeout, %0d pixels outstanding",
               $realtime, pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int phase;
    int phase_start;
    int fw;
    bit in_cfg;
    bit paused;
    in_cfg = 1'b0;
    paused = 1'b0;
    for (i = 0; i < 8; i++) code_pool[i] = 8'($urandom_range(255));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].is_cfg) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
      end else begin
        if (in_cfg) cfg_we <= 1'b0;
        in_cfg = 1'b0;
        send(directed_rows[i]);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case ($urandom_range(3))
        0: fw = 8;
        1: fw = $urandom_range(1, 8);
        2: fw = $urandom_range(9, 32);
        default: fw = $urandom_range(1, 32);
      endcase
      write_reg(CFG_FONT_WIDTH, CFG_DATA_W'(fw));
      write_reg(CFG_FONT_HEIGHT, ($urandom_range(4) == 0) ?
                CFG_DATA_W'($urandom_range(33, 63)) : CFG_DATA_W'($urandom_range(1, 32)));
      write_reg(CFG_LINE_STRIDE, ($urandom_range(5) == 0) ?
                CFG_DATA_W'($urandom_range(4097, 8191)) :
                CFG_DATA_W'($urandom_range(1, 4096)));
      write_reg(CFG_TEXT_COLOR, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
      write_reg(CFG_BG_COLOR, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
      write_reg(CFG_BG_MODE, CFG_DATA_W'($urandom_range(1)));
      cfg_we <= 1'b0;
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      phase_start = accepted_items;
      while (accepted_items - phase_start < ITEMS_PER_PHASE) begin
        // in the first phase, hold off the sender once mid-phase until every pixel is out
        if (phase == 0 && !paused && accepted_items - phase_start >= ITEMS_PER_PHASE / 2) begin
          settle();
          paused = 1'b1;
        end
        random_step();
      end
    end

    settle();
    $display("Covered %0d transactions (%0d glyph loads, %0d row renders), %0d pixels checked.",
             accepted_items, load_count, render_count, pixels_checked);
    $display("Register writes: %0d over %0d random settings plus directed extremes.",
             reg_writes, RANDOM_PHASES);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ocg_pkg.sv
design/ocg_glyph_ram.sv
design/osd_character_generator_unit.sv
tb/osd_character_generator_unit_test.sv
